### hdl/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared constants and controller/datapath interface types for the
// binary max-heap queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

   localparam int BMHQ_CAPACITY = 1024;
   localparam int BMHQ_KEY_BITS = 32;

   localparam int VALUE_BITS    = 32;
   localparam int OCC_BITS      = 11;
   localparam int RSP_DATA_BITS = ((VALUE_BITS + OCC_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_BITS  = RSP_DATA_BITS - VALUE_BITS - OCC_BITS;

   // action codes carried in req_tuser
   localparam logic ACT_INSERT  = 1'b0;
   localparam logic ACT_EXTRACT = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture the accepted item
      logic ins_begin;  // open a hole at the tail, bump count
      logic ext_begin;  // read root and last entry, drop count
      logic ext_load;   // latch root as result, last entry as sift key
      logic rd_up;      // read parent of the hole
      logic rd_down;    // read both children of the hole
      logic move;       // move the compared entry into the hole
      logic place;      // write the sift key into the hole
      logic drop;       // flag a refused insert
      logic post;       // load the output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic extract;
      logic full;
      logic empty;
      logic at_root;
      logic leaf;
      logic promote;
      logic out_busy;
   } status_type;

endpackage

### hdl/bmhq_ctrl.sv
// ----------------------------------------------------------------------------
// bmhq_ctrl
// Sequencer for insert / extract-max: walks the sift loop one tree level
// per check and compare state and hands the finished result to the output register.
// ----------------------------------------------------------------------------
module bmhq_ctrl
   import bmhq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE       = 3'd0;
   localparam logic [2:0] ST_START      = 3'd1;
   localparam logic [2:0] ST_EXT_LOAD   = 3'd2;
   localparam logic [2:0] ST_UP_CHECK   = 3'd3;
   localparam logic [2:0] ST_UP_CMP     = 3'd4;
   localparam logic [2:0] ST_DOWN_CHECK = 3'd5;
   localparam logic [2:0] ST_DOWN_CMP   = 3'd6;
   localparam logic [2:0] ST_FINISH     = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (!status.extract) begin
               if (status.full) begin
                  cmd.drop = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  cmd.ins_begin = 1'b1;
                  state_in      = ST_UP_CHECK;
               end
            end else if (status.empty) begin
               state_in = ST_FINISH;
            end else begin
               cmd.ext_begin = 1'b1;
               state_in      = ST_EXT_LOAD;
            end
         end
         ST_EXT_LOAD: begin
            cmd.ext_load = 1'b1;
            state_in     = status.empty ? ST_FINISH : ST_DOWN_CHECK;
         end
         ST_UP_CHECK: begin
            if (status.at_root) begin
               cmd.place = 1'b1;
               state_in  = ST_FINISH;
            end else begin
               cmd.rd_up = 1'b1;
               state_in  = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            if (status.promote) begin
               cmd.move = 1'b1;
               state_in = ST_UP_CHECK;
            end else begin
               cmd.place = 1'b1;
               state_in  = ST_FINISH;
            end
         end
         ST_DOWN_CHECK: begin
            if (status.leaf) begin
               cmd.place = 1'b1;
               state_in  = ST_FINISH;
            end else begin
               cmd.rd_down = 1'b1;
               state_in    = ST_DOWN_CMP;
            end
         end
         ST_DOWN_CMP: begin
            if (status.promote) begin
               cmd.move = 1'b1;
               state_in = ST_DOWN_CHECK;
            end else begin
               cmd.place = 1'b1;
               state_in  = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!status.out_busy) begin
               cmd.post = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // at most one memory write per cycle
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      !(cmd.move && cmd.place))
      else $error("move and place in the same cycle");

   // the output register is never overwritten while still held
   a_post_free: assert property (@(posedge clock) disable iff (reset)
      cmd.post |-> !status.out_busy)
      else $error("result posted into a busy output register");

   // a finished item returns to idle next cycle
   a_post_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.post |=> req_tready)
      else $error("not idle after posting a result");

endmodule

### hdl/bmhq_datapath.sv
// ----------------------------------------------------------------------------
// bmhq_datapath
// Heap memory, hole pointer, entry count, sift compare and output register.
// ----------------------------------------------------------------------------
module bmhq_datapath
   import bmhq_pkg::*;
#(
   parameter int CAPACITY = BMHQ_CAPACITY,
   parameter int KEY_BITS = BMHQ_KEY_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output status_type               status,
   input  logic [VALUE_BITS-1:0]    req_tdata,
   input  logic                     req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   output logic [1:0]               rsp_tuser
);

   localparam int KW = (KEY_BITS < VALUE_BITS) ? KEY_BITS : VALUE_BITS;
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = AW + 2;

   logic [KW-1:0] heap_mem [CAPACITY];

   logic          act_ff;
   logic [KW-1:0] cur_ff;
   logic [AW-1:0] pos_ff;
   logic [AW-1:0] tgt_ff;
   logic [CW-1:0] count_ff;
   logic [KW-1:0] rd_a_ff;
   logic [KW-1:0] rd_b_ff;
   logic [KW-1:0] removed_ff;
   logic          valid_flag_ff;
   logic          drop_flag_ff;

   logic                     rsp_valid_ff;
   logic [VALUE_BITS-1:0]    rsp_value_ff;
   logic [OCC_BITS-1:0]      rsp_occ_ff;
   logic                     rsp_rvalid_ff;
   logic                     rsp_drop_ff;

   logic [EW-1:0]  left_idx;
   logic [EW-1:0]  right_idx;
   logic [EW-1:0]  count_ext;
   logic           right_ok;
   logic [AW-1:0]  parent_idx;
   logic [AW-1:0]  addr_a;
   logic [AW-1:0]  addr_b;
   logic           rd_en;
   logic           pick_right;
   logic [KW-1:0]  pick_val;
   logic [AW-1:0]  pick_addr;
   logic           wr_en;
   logic [KW-1:0]  wr_data;
   logic [VALUE_BITS+KW-1:0]   removed_wide;
   logic [OCC_BITS+CW-1:0]     occ_wide;

   // tree geometry around the hole
   assign count_ext  = EW'(count_ff);
   assign left_idx   = (EW'(pos_ff) << 1) + EW'(1);
   assign right_idx  = left_idx + EW'(1);
   assign right_ok   = right_idx < count_ext;
   assign parent_idx = AW'((pos_ff - AW'(1)) >> 1);

   always_comb begin
      addr_a = '0;
      addr_b = '0;
      if (cmd.ext_begin) begin
         addr_b = AW'(count_ff - CW'(1));
      end else if (cmd.rd_up) begin
         addr_a = parent_idx;
      end else if (cmd.rd_down) begin
         addr_a = AW'(left_idx);
         addr_b = right_ok ? AW'(right_idx) : AW'(left_idx);
      end
   end
   assign rd_en = cmd.ext_begin | cmd.rd_up | cmd.rd_down;

   // left child wins ties; insert only ever looks at port a
   assign pick_right = act_ff && right_ok && (rd_b_ff > rd_a_ff);
   assign pick_val   = pick_right ? rd_b_ff : rd_a_ff;
   assign pick_addr  = pick_right ? (tgt_ff + AW'(1)) : tgt_ff;

   assign wr_en   = cmd.move | cmd.place;
   assign wr_data = cmd.move ? pick_val : cur_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= heap_mem[addr_a];
         rd_b_ff <= heap_mem[addr_b];
      end
      if (wr_en) begin
         heap_mem[pos_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff        <= req_tuser;
         cur_ff        <= req_tdata[KW-1:0];
         removed_ff    <= '0;
         valid_flag_ff <= 1'b0;
         drop_flag_ff  <= 1'b0;
      end
      if (cmd.ins_begin) begin
         pos_ff <= AW'(count_ff);
      end
      if (cmd.ext_begin) begin
         valid_flag_ff <= 1'b1;
      end
      if (cmd.ext_load) begin
         removed_ff <= rd_a_ff;
         cur_ff     <= rd_b_ff;
         pos_ff     <= '0;
      end
      if (cmd.rd_up) begin
         tgt_ff <= parent_idx;
      end
      if (cmd.rd_down) begin
         tgt_ff <= AW'(left_idx);
      end
      if (cmd.move) begin
         pos_ff <= pick_addr;
      end
      if (cmd.drop) begin
         drop_flag_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.ins_begin) begin
         count_ff <= count_ff + CW'(1);
      end else if (cmd.ext_begin) begin
         count_ff <= count_ff - CW'(1);
      end
   end

   // output register
   assign removed_wide = {{VALUE_BITS{1'b0}}, removed_ff};
   assign occ_wide     = {{OCC_BITS{1'b0}}, count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.post) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.post) begin
         rsp_value_ff  <= removed_wide[VALUE_BITS-1:0];
         rsp_occ_ff    <= occ_wide[OCC_BITS-1:0];
         rsp_rvalid_ff <= valid_flag_ff;
         rsp_drop_ff   <= drop_flag_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_BITS{1'b0}}, rsp_occ_ff, rsp_value_ff};
   assign rsp_tuser  = {rsp_drop_ff, rsp_rvalid_ff};

   // status back to the sequencer
   always_comb begin
      status.extract  = (act_ff == ACT_EXTRACT);
      status.full     = (count_ff == CW'(CAPACITY));
      status.empty    = (count_ff == '0);
      status.at_root  = (pos_ff == '0);
      status.leaf     = (left_idx >= count_ext);
      status.promote  = act_ff ? (pick_val > cur_ff) : (cur_ff > rd_a_ff);
      status.out_busy = rsp_valid_ff && !rsp_tready;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count beyond capacity");

   a_count_inc: assert property (@(posedge clock) disable iff (reset)
      cmd.ins_begin |=> count_ff == CW'($past(count_ff) + CW'(1)))
      else $error("insert did not grow the heap by one");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("result both removed and dropped");

endmodule

### hdl/binary_max_heap_queue_top.sv
// Steps (item taken to result valid): insert opens a hole at the tail and climbs a level
//   per check and compare state; extract reads root and last entry, then sinks a level per
//   check and compare state, with no sink for the last entry; a refused insert or an empty
//   extract goes straight to finish. Throughput: one item at a time, the next taken the cycle
//   after the result posts; a result held in the output register stalls only that post.
// Reset: synchronous, active high; empties the heap at once, no clearing pass.
// ----------------------------------------------------------------------------
// binary_max_heap_queue_top
// Binary max-heap priority queue: insert a key or extract the maximum, one
// result item for every request item.
// ----------------------------------------------------------------------------
module binary_max_heap_queue_top
   import bmhq_pkg::*;
#(
   parameter int CAPACITY = BMHQ_CAPACITY,  // entries held, 2..2047
   parameter int KEY_BITS = BMHQ_KEY_BITS   // stored key width, 1..32 (larger clamps to 32)
) (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [VALUE_BITS-1:0]    req_tdata,   // [31:0] value
   input  logic                     req_tuser,   // [0] action: 0 insert, 1 extract
   // result channel
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,   // [31:0] removed_value,
                                                 // [42:32] occupancy, rest zero
   output logic [1:0]               rsp_tuser    // [0] removed_valid,
                                                 // [1] insert_dropped
);

   // Controller and datapath talk only through these two bundles.
   cmd_type    cmd;
   status_type status;

   // Sequencer: one state per step of the sift walk.
   bmhq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Heap memory (one write, two registered reads), hole pointer, count,
   // and the output register that decouples the result channel.
   bmhq_datapath #(
      .CAPACITY (CAPACITY),
      .KEY_BITS (KEY_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
